// ===== rtl/cclr_pkg.sv =====
// Package with the shared constants, codes and types of the CRC-checked line receiver.
package cclr_pkg;

  // Longest payload plus one: a payload that reaches this length is dropped.
  localparam int MAX_LINE    = 30;
  localparam int STORE_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LEN_W       = $clog2(STORE_DEPTH + 1);

  // CRC-16/CCITT-FALSE.
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [2:0]  CRC_BITS_AFTER_START = 3'd7;

  // Framing and field characters.
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_OK           = 3'd0,
    STAT_NO_CHECK     = 3'd1,
    STAT_BAD_CHECK    = 3'd2,
    STAT_TOO_LONG     = 3'd3,
    STAT_DOUBLE_DELIM = 3'd4
  } status_t;

  // Main sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRC,
    ST_EMIT,
    ST_RD,
    ST_PUT
  } state_t;

  // Checksum field parser phases.
  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  // Requests to the bit-serial CRC unit.
  typedef struct packed {
    logic       init;
    logic       start;
    logic [7:0] data;
  } crc_ctl_t;

  // Requests to the checksum field parser.
  typedef struct packed {
    logic       clear;
    logic       step;
    logic [7:0] data;
  } prs_ctl_t;

  // Requests to the payload buffer.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } buf_req_t;

endpackage

// ===== rtl/cclr_if.sv =====
// Channel interfaces of the line receiver: received bytes in, frame results out.
interface cclr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cclr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic [15:0] computed_crc;
  logic [15:0] received_crc;
  logic        last;

  modport source (output valid, output status, output data_byte, output byte_valid,
                  output computed_crc, output received_crc, output last, input ready);
  modport sink   (input valid, input status, input data_byte, input byte_valid,
                  input computed_crc, input received_crc, input last, output ready);
endinterface

// ===== rtl/cclr_crc_unit.sv =====
// Bit-serial CRC-16/CCITT-FALSE unit: one polynomial step per clock cycle.
module cclr_crc_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  cclr_pkg::crc_ctl_t ctl,
  output logic [15:0]       crc,
  output logic              busy,
  output logic              finish
);

  logic [15:0] crc_r, crc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [15:0] seeded;
  logic [15:0] step_in;
  logic [15:0] step_out;

  // The byte is folded into the high half, and the first bit is shifted at once.
  assign seeded   = crc_r ^ {ctl.data, 8'h00};
  assign step_in  = ctl.start ? seeded : crc_r;
  assign step_out = step_in[15] ? ({step_in[14:0], 1'b0} ^ cclr_pkg::CRC_POLY)
                                : {step_in[14:0], 1'b0};

  always_comb begin
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    if (ctl.init) begin
      crc_nxt = cclr_pkg::CRC_INIT;
      cnt_nxt = '0;
    end else if (ctl.start) begin
      crc_nxt = step_out;
      cnt_nxt = cclr_pkg::CRC_BITS_AFTER_START;
    end else if (cnt_r != '0) begin
      crc_nxt = step_out;
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= cclr_pkg::CRC_INIT;
      cnt_r <= '0;
    end else begin
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign crc    = crc_r;
  assign busy   = (cnt_r != '0);
  assign finish = (cnt_r == 3'd1);

endmodule

// ===== rtl/cclr_check_parse.sv =====
// Decimal checksum field parser: skips blanks, takes a sign, accumulates digits mod 65536.
module cclr_check_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  cclr_pkg::prs_ctl_t ctl,
  output logic [15:0]        value
);

  logic [15:0]      val_r, val_nxt;
  logic             neg_r, neg_nxt;
  cclr_pkg::phase_t phase_r, phase_nxt;
  logic             is_digit;
  logic             is_blank;
  logic             is_sign;
  logic [15:0]      val_acc;

  assign is_digit = (ctl.data >= cclr_pkg::CH_ZERO) && (ctl.data <= cclr_pkg::CH_NINE);
  assign is_blank = (ctl.data == cclr_pkg::CH_SPACE) || (ctl.data == cclr_pkg::CH_VT) ||
                    (ctl.data == cclr_pkg::CH_FF);
  assign is_sign  = (ctl.data == cclr_pkg::CH_PLUS) || (ctl.data == cclr_pkg::CH_MINUS);

  // Times ten as two shifts and an add; the low nibble of an ASCII digit is its value.
  assign val_acc = {val_r[12:0], 3'b000} + {val_r[14:0], 1'b0} + {12'h000, ctl.data[3:0]};

  always_comb begin
    val_nxt   = val_r;
    neg_nxt   = neg_r;
    phase_nxt = phase_r;
    if (ctl.clear) begin
      val_nxt   = '0;
      neg_nxt   = 1'b0;
      phase_nxt = cclr_pkg::PH_SKIP;
    end else if (ctl.step) begin
      case (phase_r)
        cclr_pkg::PH_SKIP: begin
          if (is_blank) begin
            phase_nxt = cclr_pkg::PH_SKIP;
          end else if (is_sign) begin
            neg_nxt   = (ctl.data == cclr_pkg::CH_MINUS);
            phase_nxt = cclr_pkg::PH_DIGITS;
          end else if (is_digit) begin
            val_nxt   = val_acc;
            phase_nxt = cclr_pkg::PH_DIGITS;
          end else begin
            phase_nxt = cclr_pkg::PH_DONE;
          end
        end
        cclr_pkg::PH_DIGITS: begin
          if (is_digit) begin
            val_nxt = val_acc;
          end else begin
            phase_nxt = cclr_pkg::PH_DONE;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r   <= '0;
      neg_r   <= 1'b0;
      phase_r <= cclr_pkg::PH_SKIP;
    end else begin
      val_r   <= val_nxt;
      neg_r   <= neg_nxt;
      phase_r <= phase_nxt;
    end
  end

  // A minus sign negates the field modulo 65536.
  assign value = neg_r ? (16'h0000 - val_r) : val_r;

endmodule

// ===== rtl/cclr_payload_buf.sv =====
// Payload byte store: one write port and one registered read port.
module cclr_payload_buf (
  input  logic               clk,
  input  cclr_pkg::buf_req_t req,
  output logic [7:0]         rdata
);

  logic [7:0] mem_r [cclr_pkg::STORE_DEPTH];
  logic [7:0] rdata_r;

  // Write side.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  // Read side, data registered.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem_r[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/crc_checked_line_receiver.sv =====
// Top level of the CRC-checked framed line receiver: sequencer, result register, submodules.
//
//   Channel   Direction  Payload
//   in_rx     in         rx_byte[7:0]
//   out_res   out        status[2:0], data_byte[7:0], byte_valid, computed_crc[15:0],
//                        received_crc[15:0], last
//
// A payload byte is accepted, then the sequencer waits in ST_CRC while the bit-serial CRC unit
// shifts in its remaining bits; any other byte is handled as it is accepted. At frame end each
// payload byte is replayed as a buffer read, then a result load that waits while stalled.
// Input is taken only while the sequencer is idle; a waiting result does not block it.
// Reset is synchronous and active low; the payload buffer needs no clearing pass.
module crc_checked_line_receiver (
  input  logic       clk,
  input  logic       rst_n,
  cclr_in_if.sink    in_rx,
  cclr_out_if.source out_res
);

  cclr_pkg::state_t  state_r, state_nxt;
  logic              in_frame_r, in_frame_nxt;
  logic              in_check_r, in_check_nxt;
  logic              abort_r, abort_nxt;
  logic [cclr_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [cclr_pkg::ADDR_W-1:0] idx_r, idx_nxt;
  cclr_pkg::status_t res_status_r, res_status_nxt;
  logic [15:0]       res_rc_r, res_rc_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_status_r;
  logic [7:0]        out_data_r;
  logic              out_bv_r;
  logic [15:0]       out_crc_r;
  logic [15:0]       out_rc_r;
  logic              out_last_r;

  logic              accept;
  logic [7:0]        c;
  logic              out_free;
  logic              out_load;
  logic [7:0]        load_data;
  logic              load_bv;
  logic              load_last;
  logic [15:0]       load_crc;
  logic              put_last;
  logic [cclr_pkg::LEN_W-1:0] len_inc;

  cclr_pkg::crc_ctl_t crc_ctl;
  cclr_pkg::prs_ctl_t prs_ctl;
  cclr_pkg::buf_req_t buf_req;
  logic [15:0]        crc_val;
  logic               crc_busy;
  logic               crc_finish;
  logic [15:0]        field_val;
  logic [7:0]         buf_rdata;

  cclr_crc_unit u_crc (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (crc_ctl),
    .crc    (crc_val),
    .busy   (crc_busy),
    .finish (crc_finish)
  );

  cclr_check_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (prs_ctl),
    .value (field_val)
  );

  cclr_payload_buf u_buf (
    .clk   (clk),
    .req   (buf_req),
    .rdata (buf_rdata)
  );

  assign accept   = in_rx.valid && in_rx.ready;
  assign c        = in_rx.rx_byte;
  assign out_free = !out_valid_r || out_res.ready;
  assign len_inc  = len_r + cclr_pkg::LEN_W'(1);
  assign put_last = ((cclr_pkg::LEN_W'(idx_r) + cclr_pkg::LEN_W'(1)) == len_r);

  assign in_rx.ready = (state_r == cclr_pkg::ST_IDLE);

  // Dropped frames report no CRC.
  assign load_crc = ((res_status_r == cclr_pkg::STAT_TOO_LONG) ||
                     (res_status_r == cclr_pkg::STAT_DOUBLE_DELIM)) ? 16'h0000 : crc_val;

  // Sequencer: byte decode, CRC wait, single results and payload replay.
  always_comb begin
    state_nxt      = state_r;
    in_frame_nxt   = in_frame_r;
    in_check_nxt   = in_check_r;
    abort_nxt      = abort_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_rc_nxt     = res_rc_r;
    crc_ctl        = '{init: 1'b0, start: 1'b0, data: c};
    prs_ctl        = '{clear: 1'b0, step: 1'b0, data: c};
    buf_req        = '{we: 1'b0, waddr: len_r[cclr_pkg::ADDR_W-1:0], wdata: c,
                       re: 1'b0, raddr: idx_r};
    out_load       = 1'b0;
    load_data      = 8'h00;
    load_bv        = 1'b0;
    load_last      = 1'b1;
    case (state_r)
      cclr_pkg::ST_IDLE: begin
        if (accept) begin
          if ((c == cclr_pkg::CH_CR) || (c == cclr_pkg::CH_TAB)) begin
            state_nxt = cclr_pkg::ST_IDLE;
          end else if (c == cclr_pkg::CH_CARET) begin
            // A frame opens; its length, field flag, CRC and checksum parser are cleared.
            in_frame_nxt  = 1'b1;
            in_check_nxt  = 1'b0;
            len_nxt       = '0;
            crc_ctl.init  = 1'b1;
            prs_ctl.clear = 1'b1;
          end else if (!in_frame_r) begin
            state_nxt = cclr_pkg::ST_IDLE;
          end else if (c == cclr_pkg::CH_BAR) begin
            if (in_check_r) begin
              in_frame_nxt   = 1'b0;
              res_status_nxt = cclr_pkg::STAT_DOUBLE_DELIM;
              res_rc_nxt     = '0;
              state_nxt      = cclr_pkg::ST_EMIT;
            end else begin
              in_check_nxt = 1'b1;
            end
          end else if (c == cclr_pkg::CH_LF) begin
            // Frame end: settle the verdict, then replay the payload, or emit one result if it is empty.
            in_frame_nxt = 1'b0;
            idx_nxt      = '0;
            if (!in_check_r) begin
              res_status_nxt = cclr_pkg::STAT_NO_CHECK;
              res_rc_nxt     = '0;
            end else begin
              res_status_nxt = (field_val == crc_val) ? cclr_pkg::STAT_OK
                                                      : cclr_pkg::STAT_BAD_CHECK;
              res_rc_nxt     = field_val;
            end
            state_nxt = (len_r == '0) ? cclr_pkg::ST_EMIT : cclr_pkg::ST_RD;
          end else if (in_check_r) begin
            prs_ctl.step = 1'b1;
          end else begin
            // Payload byte: store it, start the CRC, check the length.
            buf_req.we    = 1'b1;
            crc_ctl.start = 1'b1;
            len_nxt       = len_inc;
            abort_nxt     = (len_inc >= cclr_pkg::LEN_W'(cclr_pkg::MAX_LINE)) ||
                            (len_inc >= cclr_pkg::LEN_W'(cclr_pkg::STORE_DEPTH));
            if (abort_nxt) begin
              in_frame_nxt   = 1'b0;
              res_status_nxt = cclr_pkg::STAT_TOO_LONG;
              res_rc_nxt     = '0;
            end
            state_nxt = cclr_pkg::ST_CRC;
          end
        end
      end
      cclr_pkg::ST_CRC: begin
        if (crc_finish) begin
          state_nxt = abort_r ? cclr_pkg::ST_EMIT : cclr_pkg::ST_IDLE;
        end
      end
      cclr_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = cclr_pkg::ST_IDLE;
        end
      end
      cclr_pkg::ST_RD: begin
        buf_req.re = 1'b1;
        state_nxt  = cclr_pkg::ST_PUT;
      end
      cclr_pkg::ST_PUT: begin
        load_data = buf_rdata;
        load_bv   = 1'b1;
        load_last = put_last;
        if (out_free) begin
          out_load = 1'b1;
          if (put_last) begin
            state_nxt = cclr_pkg::ST_IDLE;
          end else begin
            idx_nxt   = idx_r + cclr_pkg::ADDR_W'(1);
            state_nxt = cclr_pkg::ST_RD;
          end
        end
      end
      default: begin
        state_nxt = cclr_pkg::ST_IDLE;
      end
    endcase
  end

  // Result register valid flag.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cclr_pkg::ST_IDLE;
      in_frame_r   <= 1'b0;
      in_check_r   <= 1'b0;
      abort_r      <= 1'b0;
      len_r        <= '0;
      idx_r        <= '0;
      res_status_r <= cclr_pkg::STAT_OK;
      res_rc_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_frame_r   <= in_frame_nxt;
      in_check_r   <= in_check_nxt;
      abort_r      <= abort_nxt;
      len_r        <= len_nxt;
      idx_r        <= idx_nxt;
      res_status_r <= res_status_nxt;
      res_rc_r     <= res_rc_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_data_r   <= load_data;
      out_bv_r     <= load_bv;
      out_crc_r    <= load_crc;
      out_rc_r     <= res_rc_r;
      out_last_r   <= load_last;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.status       = out_status_r;
  assign out_res.data_byte    = out_data_r;
  assign out_res.byte_valid   = out_bv_r;
  assign out_res.computed_crc = out_crc_r;
  assign out_res.received_crc = out_rc_r;
  assign out_res.last         = out_last_r;

`ifndef SYNTHESIS
  // The CRC unit only runs while the sequencer waits for it.
  a_crc_only_in_crc_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != cclr_pkg::ST_CRC) |-> !crc_busy)
    else $error("CRC unit busy outside the CRC wait state");

  // A replayed byte always lies inside the stored payload.
  a_replay_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cclr_pkg::ST_PUT) |-> (cclr_pkg::LEN_W'(idx_r) < len_r))
    else $error("Replay index beyond payload length");

  // An open frame never holds a payload of the dropping length.
  a_frame_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> (len_r < cclr_pkg::LEN_W'(cclr_pkg::MAX_LINE)))
    else $error("Open frame reached the maximum line length");

  // Loading the final replayed byte returns the sequencer to idle.
  a_last_ends_replay: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cclr_pkg::ST_PUT && out_free && put_last) |=> (state_r == cclr_pkg::ST_IDLE))
    else $error("Replay did not end after the last byte");
`endif

endmodule

// ===== tb/crc_checked_line_receiver_checker.sv =====
`timescale 1ns / 100ps
// Checker for the line receiver: predicts frame results from accepted bytes and compares them.
module crc_checked_line_receiver_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic [7:0]  out_data_byte,
  input  logic        out_byte_valid,
  input  logic [15:0] out_computed_crc,
  input  logic [15:0] out_received_crc,
  input  logic        out_last,
  output int          fail_count,
  output int          expect_count
);

  typedef struct packed {
    cclr_pkg::status_t status;
    logic [7:0]        data_byte;
    logic              byte_valid;
    logic [15:0]       computed_crc;
    logic [15:0]       received_crc;
    logic              last;
  } frame_result_t;

  // Results still owed by the block, oldest first.
  frame_result_t result_q[$];

  // Shadow copy of the receiver's framing and checksum state.
  logic             frame_open;
  logic             field_open;
  logic [15:0]      crc_acc;
  logic [7:0]       payload_mem [cclr_pkg::STORE_DEPTH];
  int               payload_len;
  logic [15:0]      field_value;
  logic             field_neg;
  cclr_pkg::phase_t field_phase;

  initial begin
    fail_count   = 0;
    expect_count = 0;
  end

  function automatic frame_result_t make_result(input cclr_pkg::status_t st,
                                                input logic [7:0] db,
                                                input logic bv, input logic [15:0] cc,
                                                input logic [15:0] rc, input logic la);
    frame_result_t r;
    r.status       = st;
    r.data_byte    = db;
    r.byte_valid   = bv;
    r.computed_crc = cc;
    r.received_crc = rc;
    r.last         = la;
    return r;
  endfunction

  // One byte through the MSB-first CRC-16/CCITT-FALSE shift register.
  function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] acc;
    acc = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      acc = acc[15] ? ((acc << 1) ^ cclr_pkg::CRC_POLY) : (acc << 1);
    end
    return acc;
  endfunction

  task automatic clear_frame();
    frame_open  = 1'b0;
    field_open  = 1'b0;
    crc_acc     = cclr_pkg::CRC_INIT;
    payload_len = 0;
    field_value = 16'd0;
    field_neg   = 1'b0;
    field_phase = cclr_pkg::PH_SKIP;
  endtask

  // Decimal checksum field, read the way atol reads it, modulo 65536.
  task automatic parse_field(input logic [7:0] ch);
    logic digit;
    digit = (ch >= cclr_pkg::CH_ZERO) && (ch <= cclr_pkg::CH_NINE);
    if (field_phase == cclr_pkg::PH_SKIP) begin
      if (ch == cclr_pkg::CH_SPACE || ch == cclr_pkg::CH_VT || ch == cclr_pkg::CH_FF) return;
      if (ch == cclr_pkg::CH_PLUS || ch == cclr_pkg::CH_MINUS) begin
        field_neg   = (ch == cclr_pkg::CH_MINUS);
        field_phase = cclr_pkg::PH_DIGITS;
        return;
      end
      field_phase = digit ? cclr_pkg::PH_DIGITS : cclr_pkg::PH_DONE;
    end
    if (field_phase == cclr_pkg::PH_DIGITS) begin
      if (digit) begin
        field_value = field_value * 16'd10 + {8'd0, ch - cclr_pkg::CH_ZERO};
      end else begin
        field_phase = cclr_pkg::PH_DONE;
      end
    end
  endtask

  // Advance the shadow state by one received byte and queue whatever results it causes.
  task automatic predict_byte(input logic [7:0] ch);
    logic [15:0]       rcv;
    cclr_pkg::status_t st;
    if (ch == cclr_pkg::CH_CR || ch == cclr_pkg::CH_TAB) return;
    if (ch == cclr_pkg::CH_CARET) begin
      clear_frame();
      frame_open = 1'b1;
      return;
    end
    if (!frame_open) return;

    if (ch == cclr_pkg::CH_BAR) begin
      if (field_open) begin
        frame_open = 1'b0;
        result_q.push_back(make_result(cclr_pkg::STAT_DOUBLE_DELIM, 8'd0, 1'b0, 16'd0,
                                       16'd0, 1'b1));
      end else begin
        field_open = 1'b1;
      end
      return;
    end

    // End of line: verdict, then the payload replayed as one run.
    if (ch == cclr_pkg::CH_LF) begin
      frame_open = 1'b0;
      rcv = 16'd0;
      if (!field_open) begin
        st = cclr_pkg::STAT_NO_CHECK;
      end else begin
        rcv = field_neg ? (16'd0 - field_value) : field_value;
        st  = (rcv == crc_acc) ? cclr_pkg::STAT_OK : cclr_pkg::STAT_BAD_CHECK;
      end
      if (payload_len == 0) begin
        result_q.push_back(make_result(st, 8'd0, 1'b0, crc_acc, rcv, 1'b1));
      end else begin
        for (int k = 0; k < payload_len; k++) begin
          result_q.push_back(make_result(st, payload_mem[k], 1'b1, crc_acc, rcv,
                                         k == payload_len - 1));
        end
      end
      return;
    end

    if (field_open) begin
      parse_field(ch);
      return;
    end

    // Payload byte: store it, fold it into the CRC, drop the frame when it gets too long.
    if (payload_len < cclr_pkg::STORE_DEPTH) payload_mem[payload_len] = ch;
    payload_len++;
    crc_acc = crc_update(crc_acc, ch);
    if (payload_len >= cclr_pkg::MAX_LINE || payload_len >= cclr_pkg::STORE_DEPTH) begin
      frame_open = 1'b0;
      result_q.push_back(make_result(cclr_pkg::STAT_TOO_LONG, 8'd0, 1'b0, 16'd0, 16'd0,
                                     1'b1));
    end
  endtask

  // Results are compared before the same edge's request is predicted; a request
  // can never cause a result at the edge that accepts it.
  always @(posedge clk) begin : sample
    frame_result_t got;
    frame_result_t want;
    if (!rst_n) begin
      clear_frame();
      result_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = make_result(cclr_pkg::status_t'(out_status), out_data_byte, out_byte_valid,
                          out_computed_crc, out_received_crc, out_last);
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result status=%0d data=%02h bv=%0d",
                     $time, got.status, got.data_byte, got.byte_valid,
                     " crc=%04h rcv=%04h last=%0d",
                     got.computed_crc, got.received_crc, got.last);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch, expected status=%0d data=%02h bv=%0d",
                       $time, want.status, want.data_byte, want.byte_valid,
                       " crc=%04h rcv=%04h last=%0d",
                       want.computed_crc, want.received_crc, want.last);
              $display("%0t:           actual   status=%0d data=%02h bv=%0d",
                       $time, got.status, got.data_byte, got.byte_valid,
                       " crc=%04h rcv=%04h last=%0d",
                       got.computed_crc, got.received_crc, got.last);
            end
          end
        end
      end
      if (in_valid && in_ready) predict_byte(in_rx_byte);
    end
    expect_count = result_q.size();
  end

endmodule

// ===== tb/crc_checked_line_receiver_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the line receiver: clock, reset, byte stimulus, flow control and verdict.
module crc_checked_line_receiver_tb;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_REQUESTS = 95;

  logic clk;
  logic rst_n;

  cclr_in_if  in_rx ();
  cclr_out_if out_res ();

  int         fail_count;
  int         expect_count;
  int         sender_idle_pct;
  int         sink_stall_pct;
  int         requests_sent;
  int         cycle_count;
  logic [7:0] line_q[$];

  crc_checked_line_receiver dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_rx   (in_rx),
    .out_res (out_res)
  );

  crc_checked_line_receiver_checker line_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_rx.valid),
    .in_ready         (in_rx.ready),
    .in_rx_byte       (in_rx.rx_byte),
    .out_valid        (out_res.valid),
    .out_ready        (out_res.ready),
    .out_status       (out_res.status),
    .out_data_byte    (out_res.data_byte),
    .out_byte_valid   (out_res.byte_valid),
    .out_computed_crc (out_res.computed_crc),
    .out_received_crc (out_res.received_crc),
    .out_last         (out_res.last),
    .fail_count       (fail_count),
    .expect_count     (expect_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    out_res.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Checksums for well-formed frames are built with the same CRC the line carries.
  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] acc;
    acc = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      acc = acc[15] ? ((acc << 1) ^ cclr_pkg::CRC_POLY) : (acc << 1);
    end
    return acc;
  endfunction

  // Any byte that carries no framing meaning.
  function automatic logic [7:0] payload_char();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b == cclr_pkg::CH_CARET || b == cclr_pkg::CH_BAR || b == cclr_pkg::CH_LF ||
               b == cclr_pkg::CH_CR || b == cclr_pkg::CH_TAB);
    return b;
  endfunction

  // Present one request at the falling edge and hold it until it is taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_rx.valid <= 1'b0;
      @(negedge clk);
    end
    in_rx.valid   <= 1'b1;
    in_rx.rx_byte <= b;
    @(posedge clk);
    while (!in_rx.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_line();
    requests_sent += line_q.size();
    while (line_q.size() > 0) send_byte(line_q.pop_front());
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic push_decimal(input int unsigned v);
    logic [7:0] dig [12];
    int         n;
    n = 0;
    do begin
      dig[n] = 8'(v % 10);
      n++;
      v = v / 10;
    end while (v != 0);
    for (int i = n - 1; i >= 0; i--) line_q.push_back(cclr_pkg::CH_ZERO + dig[i]);
  endtask

  // Stop sending and wait for every owed result.
  task automatic drain();
    in_rx.valid <= 1'b0;
    @(negedge clk);
    while (expect_count != 0) @(negedge clk);
  endtask

  // Bytes between frames; a caret is left out so they open none, but a frame left open takes them.
  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(4, 1)) begin
      do b = 8'($urandom_range(255)); while (b == cclr_pkg::CH_CARET);
      requests_sent++;
      send_byte(b);
    end
  endtask

  // One frame with random payload and a checksum field of a random flavor.
  task automatic random_frame();
    int          len;
    int          pick;
    logic [15:0] crc;
    logic [7:0]  b;
    line_q.push_back(cclr_pkg::CH_CARET);
    crc  = cclr_pkg::CRC_INIT;
    pick = $urandom_range(99);
    len  = (pick < 70) ? $urandom_range(6) :
           (pick < 90) ? $urandom_range(20, 7) : $urandom_range(31, 28);
    for (int i = 0; i < len; i++) begin
      b = payload_char();
      line_q.push_back(b);
      crc = crc_next(crc, b);
      if ($urandom_range(19) == 0) begin
        line_q.push_back($urandom_range(1) ? cclr_pkg::CH_CR : cclr_pkg::CH_TAB);
      end
    end
    case ($urandom_range(9))
      0: begin
        // No checksum field at all.
      end
      1, 2, 3: begin
        line_q.push_back(cclr_pkg::CH_BAR);
        push_decimal(crc);
      end
      4: begin
        // Optional leading white space, explicit plus, a value that may pass 16 bits and trailing junk.
        line_q.push_back(cclr_pkg::CH_BAR);
        repeat ($urandom_range(2)) begin
          pick = $urandom_range(2);
          line_q.push_back(pick == 0 ? cclr_pkg::CH_SPACE :
                           pick == 1 ? cclr_pkg::CH_VT : cclr_pkg::CH_FF);
        end
        line_q.push_back(cclr_pkg::CH_PLUS);
        push_decimal(crc + 65536 * $urandom_range(3));
        line_q.push_back(payload_char());
      end
      5: begin
        line_q.push_back(cclr_pkg::CH_BAR);
        line_q.push_back(cclr_pkg::CH_MINUS);
        push_decimal(65536 - crc);
      end
      6: begin
        line_q.push_back(cclr_pkg::CH_BAR);
        push_decimal(crc ^ (16'd1 << $urandom_range(15)));
      end
      7: begin
        // Loose field content, mostly digits.
        line_q.push_back(cclr_pkg::CH_BAR);
        repeat ($urandom_range(6)) begin
          b = $urandom_range(1) ? 8'(cclr_pkg::CH_ZERO + $urandom_range(9)) : payload_char();
          line_q.push_back(b);
        end
      end
      8: begin
        line_q.push_back(cclr_pkg::CH_BAR);
        if ($urandom_range(1)) push_decimal($urandom_range(65535));
        line_q.push_back(cclr_pkg::CH_BAR);
      end
      default: begin
        // Long digit run that may wrap the field value.
        line_q.push_back(cclr_pkg::CH_BAR);
        repeat ($urandom_range(9, 5)) begin
          b = 8'(cclr_pkg::CH_ZERO + $urandom_range(9));
          line_q.push_back(b);
        end
      end
    endcase
    // Now and then the line break is lost and the next caret restarts the frame.
    if ($urandom_range(15) != 0) line_q.push_back(cclr_pkg::CH_LF);
    send_line();
  endtask

  initial begin : stimulus
    logic [7:0]  extreme_bytes [4];
    logic [15:0] crc;
    int          idle_set  [4];
    int          stall_set [4];
    int          target;
    extreme_bytes = '{8'hFF, 8'h00, 8'h80, 8'h7F};
    idle_set      = '{0, 85, 0, 28};
    stall_set     = '{0, 0, 85, 28};
    rst_n           = 1'b0;
    in_rx.valid     = 1'b0;
    in_rx.rx_byte   = 8'h00;
    out_res.ready   = 1'b0;
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    requests_sent   = 0;
    cycle_count     = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Stray bytes outside any frame are dropped.
    push_text("Q|\n");
    // Empty frame without a checksum field.
    push_text("^\n");
    // Extreme payload bytes with a matching checksum.
    line_q.push_back(cclr_pkg::CH_CARET);
    crc = cclr_pkg::CRC_INIT;
    for (int i = 0; i < 4; i++) begin
      line_q.push_back(extreme_bytes[i]);
      crc = crc_next(crc, extreme_bytes[i]);
    end
    line_q.push_back(cclr_pkg::CH_BAR);
    push_decimal(crc);
    line_q.push_back(cclr_pkg::CH_LF);
    // Empty payload, ignored CR and TAB, skipped white space, negative field equal to the seed.
    line_q.push_back(cclr_pkg::CH_CARET);
    line_q.push_back(cclr_pkg::CH_CR);
    line_q.push_back(cclr_pkg::CH_BAR);
    line_q.push_back(cclr_pkg::CH_TAB);
    line_q.push_back(cclr_pkg::CH_VT);
    line_q.push_back(cclr_pkg::CH_FF);
    line_q.push_back(cclr_pkg::CH_SPACE);
    push_text("-1\n");
    // Wrong checksum, then a second delimiter.
    push_text("^Z|7\n");
    push_text("^a||\n");
    // Payload that runs into the length limit.
    line_q.push_back(cclr_pkg::CH_CARET);
    for (int i = 0; i < cclr_pkg::MAX_LINE; i++) line_q.push_back(8'(8'h61 + (i % 20)));
    line_q.push_back(cclr_pkg::CH_LF);
    send_line();
    drain();

    // Random frames under each flow-control mix, draining between mixes.
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = idle_set[p];
      sink_stall_pct  = stall_set[p];
      target = requests_sent + PHASE_REQUESTS;
      while (requests_sent < target) begin
        if ($urandom_range(9) == 0) send_noise();
        random_frame();
      end
      drain();
    end

    repeat (64) @(negedge clk);
    if (fail_count == 0 && expect_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
